// File: rtl/core/xcr_pkg.sv
package xcr_pkg;

  localparam int BLOCK_BYTES  = 128;
  localparam int BUFFER_BYTES = 65536;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] HDR_CPL_XOR = 8'hff;

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_CANCEL = 3'd2;
  localparam logic [2:0] ST_PROTO  = 3'd3;
  localparam logic [2:0] ST_OVER   = 3'd4;

  localparam logic [23:0] NAK_INTERVAL_RST = 24'd2000000;

  // frame layout: block number, complement, data, checksum
  localparam logic [7:0] POS_BLK      = 8'd0;
  localparam logic [7:0] POS_CPL      = 8'd1;
  localparam logic [7:0] POS_DATA     = 8'd2;
  localparam logic [7:0] POS_CSUM     = 8'(BLOCK_BYTES + 2);
  localparam logic [16:0] BLOCK_INC   = 17'(BLOCK_BYTES);
  localparam logic [16:0] SOH_MAX_CNT = 17'(BUFFER_BYTES - BLOCK_BYTES);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_SOH   = 3'd1,
    CMD_EOT   = 3'd2,
    CMD_CAN   = 3'd3,
    CMD_OTHER = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic [2:0]  status;
    logic [16:0] received_bytes;
  } out_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] rx_byte;
  } cmd_t;

endpackage

// File: rtl/core/xcr_front.sv
module xcr_front (
  input  logic          in_push,
  output logic          in_full,
  input  xcr_pkg::in_t  in_data,
  output logic          cq_push,
  output xcr_pkg::cmd_t cq_cmd,
  input  logic          cq_full
);
  import xcr_pkg::*;

  assign in_full = cq_full;
  assign cq_push = in_push && !cq_full;

  // classify the beat so the back end switches on a small code
  always_comb begin
    cq_cmd.rx_byte = in_data.rx_byte;
    if (in_data.opcode) begin
      cq_cmd.kind = CMD_TICK;
    end else begin
      case (in_data.rx_byte)
        CH_SOH:  cq_cmd.kind = CMD_SOH;
        CH_EOT:  cq_cmd.kind = CMD_EOT;
        CH_CAN:  cq_cmd.kind = CMD_CAN;
        default: cq_cmd.kind = CMD_OTHER;
      endcase
    end
  end

endmodule

// File: rtl/core/xcr_cmd_queue.sv
module xcr_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xcr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output xcr_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import xcr_pkg::*;

  cmd_t              mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]    count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (CQ_AW+1)'(CQ_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/xcr_back.sv
module xcr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [23:0]   cfg_wdata,
  input  xcr_pkg::cmd_t cq_cmd,
  input  logic          cq_empty,
  output logic          cq_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output xcr_pkg::out_t out_data
);
  import xcr_pkg::*;

  logic [23:0] nak_interval_r;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  frame_pos_r, frame_pos_nxt;
  logic [7:0]  expected_block_r, expected_block_nxt;
  logic [7:0]  got_block_r, got_block_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic        frame_bad_r, frame_bad_nxt;
  logic        started_r, started_nxt;
  logic [23:0] idle_count_r, idle_count_nxt;
  logic [16:0] byte_count_r, byte_count_nxt;
  logic [2:0]  final_status_r, final_status_nxt;
  logic [23:0] idle_inc;
  logic        csum_bad;
  out_t        res;

  // two-entry result queue
  out_t        oq_mem_r [2];
  logic        oq_wr_r, oq_rd_r;
  logic [1:0]  oq_count_r, oq_count_nxt;
  logic        oq_pop;

  assign cq_pop    = !cq_empty && (oq_count_r != 2'd2);
  assign oq_pop    = out_pop && (oq_count_r != 2'd0);
  assign out_empty = (oq_count_r == 2'd0);
  assign out_data  = oq_mem_r[oq_rd_r];
  assign idle_inc  = idle_count_r + 24'd1;
  assign csum_bad  = (running_sum_r != cq_cmd.rx_byte);

  always_comb begin
    in_frame_nxt       = in_frame_r;
    frame_pos_nxt      = frame_pos_r;
    expected_block_nxt = expected_block_r;
    got_block_nxt      = got_block_r;
    running_sum_nxt    = running_sum_r;
    frame_bad_nxt      = frame_bad_r;
    started_nxt        = started_r;
    idle_count_nxt     = idle_count_r;
    byte_count_nxt     = byte_count_r;
    final_status_nxt   = final_status_r;
    res                = '0;

    if (final_status_r == ST_RUN) begin
      if (cq_cmd.kind == CMD_TICK) begin
        if (!started_r && !in_frame_r) begin
          if (idle_inc >= nak_interval_r) begin
            idle_count_nxt = '0;
            res.tx_valid   = 1'b1;
            res.tx_byte    = CH_NAK;
          end else begin
            idle_count_nxt = idle_inc;
          end
        end
      end else if (in_frame_r) begin
        frame_pos_nxt = frame_pos_r + 8'd1;
        if (frame_pos_r == POS_BLK) begin
          got_block_nxt = cq_cmd.rx_byte;
          if (cq_cmd.rx_byte != expected_block_r) begin
            frame_bad_nxt = 1'b1;
          end
        end else if (frame_pos_r == POS_CPL) begin
          if ((got_block_r ^ cq_cmd.rx_byte) != HDR_CPL_XOR) begin
            frame_bad_nxt = 1'b1;
          end
        end else if (frame_pos_r < POS_CSUM) begin
          res.wr_valid    = 1'b1;
          res.wr_addr     = byte_count_r[15:0] + {8'd0, frame_pos_r - POS_DATA};
          res.wr_data     = cq_cmd.rx_byte;
          running_sum_nxt = running_sum_r + cq_cmd.rx_byte;
        end else begin
          res.tx_valid  = 1'b1;
          in_frame_nxt  = 1'b0;
          frame_pos_nxt = '0;
          if (frame_bad_r || csum_bad) begin
            frame_bad_nxt = 1'b1;
            res.tx_byte   = CH_NAK;
          end else begin
            res.tx_byte        = CH_ACK;
            expected_block_nxt = expected_block_r + 8'd1;
            byte_count_nxt     = byte_count_r + BLOCK_INC;
          end
        end
      end else begin
        idle_count_nxt = '0;
        case (cq_cmd.kind)
          CMD_EOT: begin
            res.tx_valid     = 1'b1;
            res.tx_byte      = CH_ACK;
            final_status_nxt = ST_DONE;
          end
          CMD_CAN: begin
            final_status_nxt = ST_CANCEL;
          end
          CMD_SOH: begin
            started_nxt = 1'b1;
            if (byte_count_r > SOH_MAX_CNT) begin
              final_status_nxt = ST_OVER;
            end else begin
              in_frame_nxt    = 1'b1;
              frame_pos_nxt   = '0;
              running_sum_nxt = '0;
              frame_bad_nxt   = 1'b0;
              got_block_nxt   = '0;
            end
          end
          default: begin
            if (started_r) begin
              final_status_nxt = ST_PROTO;
            end
          end
        endcase
      end
    end

    res.status         = final_status_nxt;
    res.received_bytes = byte_count_nxt;
  end

  always_comb begin
    oq_count_nxt = oq_count_r;
    if (cq_pop && !oq_pop) begin
      oq_count_nxt = oq_count_r + 2'd1;
    end else if (oq_pop && !cq_pop) begin
      oq_count_nxt = oq_count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nak_interval_r   <= NAK_INTERVAL_RST;
      in_frame_r       <= 1'b0;
      frame_pos_r      <= '0;
      expected_block_r <= 8'd1;
      got_block_r      <= '0;
      running_sum_r    <= '0;
      frame_bad_r      <= 1'b0;
      started_r        <= 1'b0;
      idle_count_r     <= '0;
      byte_count_r     <= '0;
      final_status_r   <= ST_RUN;
      oq_wr_r          <= 1'b0;
      oq_rd_r          <= 1'b0;
      oq_count_r       <= '0;
    end else begin
      if (cfg_we) begin
        nak_interval_r <= cfg_wdata;
      end
      if (cq_pop) begin
        in_frame_r       <= in_frame_nxt;
        frame_pos_r      <= frame_pos_nxt;
        expected_block_r <= expected_block_nxt;
        got_block_r      <= got_block_nxt;
        running_sum_r    <= running_sum_nxt;
        frame_bad_r      <= frame_bad_nxt;
        started_r        <= started_nxt;
        idle_count_r     <= idle_count_nxt;
        byte_count_r     <= byte_count_nxt;
        final_status_r   <= final_status_nxt;
        oq_wr_r          <= !oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= !oq_rd_r;
      end
      oq_count_r <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

endmodule

// File: rtl/core/xmodem_checksum_receiver_core.sv
// channel  ports                                   beat
// input    in_push, in_full, in_data               opcode, rx_byte
// result   out_empty, out_pop, out_data            reply, buffer write, status, count
// config   cfg_we, cfg_wdata                       nak_interval (24 bit)
//
// one beat per cycle sustained while the result side keeps popping; a result reaches
// the out ports through the 4-entry command queue and then the 2-entry result queue (the
// back end writes the result queue on the edge that pops the command queue)
// the protocol state machine in the back end handles one command per cycle whenever the
// result queue has room; reset is synchronous and clears both queues and all protocol state
// a stalled result side fills the result queue, then the command queue, then raises in_full
module xmodem_checksum_receiver_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  xcr_pkg::in_t   in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output xcr_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [23:0]    cfg_wdata
);
  import xcr_pkg::*;

  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wr_cmd, cq_rd_cmd;

  xcr_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cq_push (cq_push),
    .cq_cmd  (cq_wr_cmd),
    .cq_full (cq_full)
  );

  xcr_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_wr_cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .pop_cmd  (cq_rd_cmd),
    .empty    (cq_empty)
  );

  xcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cq_cmd    (cq_rd_cmd),
    .cq_empty  (cq_empty),
    .cq_pop    (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: sim/testbench.sv
module testbench;
  import xcr_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 80;
  localparam int CALM_FROM = 450;
  localparam int CALM_TO = 650;
  localparam int RANDOM_ITEMS = 900;

  typedef enum int {FR_GOOD, FR_BAD_BLK, FR_BAD_CPL, FR_BAD_SUM} frame_kind_t;
  typedef enum int {END_EOT, END_CAN, END_PROTO} ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_t         in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  xmodem_checksum_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver state as predicted
  logic [23:0] m_nak_every = NAK_INTERVAL_RST;
  logic        m_in_frame = 1'b0;
  logic [7:0]  m_pos = '0;
  logic [7:0]  m_expect_blk = 8'd1;
  logic [7:0]  m_got_blk = '0;
  logic [7:0]  m_sum = '0;
  logic        m_bad = 1'b0;
  logic        m_started = 1'b0;
  logic [23:0] m_idle = '0;
  logic [16:0] m_count = '0;
  logic [2:0]  m_status = ST_RUN;

  in_t  rx_stream[$];
  out_t predicted_beats[$];
  out_t want_beat;
  int   n_queued = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   stall_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   in_taken = 1'b0;
  bit   out_taken = 1'b0;

  // sender side of stimulus generation
  logic [7:0] gen_blk = 8'd1;

  function automatic out_t xmodem_rx_predict(in_t beat);
    out_t r;
    r = '0;
    if (m_status == ST_RUN) begin
      if (beat.opcode == OP_TICK) begin
        if (!m_started && !m_in_frame) begin
          m_idle = m_idle + 24'd1;
          if (m_idle >= m_nak_every) begin
            m_idle = '0;
            r.tx_valid = 1'b1;
            r.tx_byte = CH_NAK;
          end
        end
      end else if (m_in_frame) begin
        if (m_pos == POS_BLK) begin
          m_got_blk = beat.rx_byte;
          if (beat.rx_byte != m_expect_blk) m_bad = 1'b1;
        end else if (m_pos == POS_CPL) begin
          if ((m_got_blk ^ beat.rx_byte) != HDR_CPL_XOR) m_bad = 1'b1;
        end else if (m_pos < POS_CSUM) begin
          r.wr_valid = 1'b1;
          r.wr_addr = m_count[15:0] + 16'(m_pos - POS_DATA);
          r.wr_data = beat.rx_byte;
          m_sum = m_sum + beat.rx_byte;
        end else begin
          if (m_sum != beat.rx_byte) m_bad = 1'b1;
          r.tx_valid = 1'b1;
          if (m_bad) begin
            r.tx_byte = CH_NAK;
          end else begin
            r.tx_byte = CH_ACK;
            m_expect_blk = m_expect_blk + 8'd1;
            m_count = m_count + BLOCK_INC;
          end
          m_in_frame = 1'b0;
        end
        m_pos = m_in_frame ? m_pos + 8'd1 : '0;
      end else begin
        m_idle = '0;
        case (beat.rx_byte)
          CH_EOT: begin
            r.tx_valid = 1'b1;
            r.tx_byte = CH_ACK;
            m_status = ST_DONE;
          end
          CH_CAN: m_status = ST_CANCEL;
          CH_SOH: begin
            m_started = 1'b1;
            if (m_count > SOH_MAX_CNT) begin
              m_status = ST_OVER;
            end else begin
              m_in_frame = 1'b1;
              m_pos = '0;
              m_sum = '0;
              m_bad = 1'b0;
              m_got_blk = '0;
            end
          end
          default: if (m_started) m_status = ST_PROTO;
        endcase
      end
    end
    r.status = m_status;
    r.received_bytes = m_count;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // input and result beats are sampled in one place so a same-edge result stays ordered
  always @(posedge clk) begin
    in_taken = rst_n && in_push && !in_full;
    out_taken = rst_n && out_pop && !out_empty;
    if (in_taken) begin
      predicted_beats.push_back(xmodem_rx_predict(in_data));
      items_taken++;
    end
    if (out_taken) begin
      results_seen++;
      if (predicted_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want_beat = predicted_beats.pop_front();
        check_field("tx_valid", want_beat.tx_valid, out_data.tx_valid);
        check_field("tx_byte", want_beat.tx_byte, out_data.tx_byte);
        check_field("wr_valid", want_beat.wr_valid, out_data.wr_valid);
        check_field("wr_addr", want_beat.wr_addr, out_data.wr_addr);
        check_field("wr_data", want_beat.wr_data, out_data.wr_data);
        check_field("status", want_beat.status, out_data.status);
        check_field("received_bytes", want_beat.received_bytes, out_data.received_bytes);
      end
    end
    if (rst_n && results_seen != n_queued && !in_taken && !out_taken) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  // driver: holds a beat until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (rx_stream.size() > 0 &&
          ((items_taken >= CALM_FROM && items_taken < CALM_TO) || $urandom_range(99) >= 14)) begin
        in_push <= 1'b1;
        in_data <= rx_stream.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor pop side, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rst_n &&
        ((results_seen >= CALM_FROM && results_seen < CALM_TO) || $urandom_range(99) >= 14);
    end
  end

  task automatic queue_item(logic op, logic [7:0] b);
    in_t it;
    it.opcode = op;
    it.rx_byte = b;
    rx_stream.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
    return b;
  endfunction

  // frame byte, now and then preceded by a tick that the block must skip
  task automatic queue_framed(logic [7:0] b, bit sprinkle);
    if (sprinkle && $urandom_range(24) == 0) queue_item(OP_TICK, 8'($urandom));
    queue_item(OP_BYTE, b);
  endtask

  task automatic queue_frame(frame_kind_t kind, bit sprinkle);
    logic [7:0] blk;
    logic [7:0] cpl;
    logic [7:0] sum;
    logic [7:0] d;
    int fill;
    blk = gen_blk;
    if (kind == FR_BAD_BLK) begin
      if ($urandom_range(1) == 0) blk = gen_blk - 8'd1;   // resent previous block
      else blk = gen_blk ^ 8'($urandom_range(1, 255));
    end
    cpl = ~blk;
    if (kind == FR_BAD_CPL) cpl = cpl ^ 8'($urandom_range(1, 255));
    fill = $urandom_range(7);
    sum = '0;
    queue_item(OP_BYTE, CH_SOH);
    queue_framed(blk, sprinkle);
    queue_framed(cpl, sprinkle);
    repeat (BLOCK_BYTES) begin
      d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom);
      sum = sum + d;
      queue_framed(d, sprinkle);
    end
    if (kind == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    queue_framed(sum, sprinkle);
    if (kind == FR_GOOD) begin
      gen_blk = gen_blk + 8'd1;
    end
  endtask

  // register writes only once every queued beat has come back
  task automatic write_nak_interval(logic [23:0] v);
    while (results_seen != n_queued) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    m_nak_every = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pick;
    ending_t finale;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset interval: no nak, stray bytes before start are ignored
    queue_item(OP_TICK, 8'h00);
    queue_item(OP_TICK, 8'hff);
    queue_item(OP_BYTE, 8'hff);
    queue_item(OP_BYTE, 8'h00);
    queue_item(OP_TICK, 8'h5a);

    write_nak_interval(24'd1);
    repeat (3) queue_item(OP_TICK, 8'($urandom));
    queue_item(OP_BYTE, CH_ACK);
    queue_item(OP_TICK, 8'($urandom));

    write_nak_interval(24'hffffff);
    repeat (3) queue_item(OP_TICK, 8'($urandom));
    queue_item(OP_BYTE, CH_NAK);

    // a received byte restarts the idle count
    write_nak_interval(24'd3);
    repeat (2) queue_item(OP_TICK, 8'($urandom));
    queue_item(OP_BYTE, 8'h80);
    repeat (6) queue_item(OP_TICK, 8'($urandom));

    for (int ph = 0; ph < 4; ph++) begin
      if (ph < 3) write_nak_interval(24'($urandom_range(1, 6)));
      else write_nak_interval(24'($urandom_range(1, 16777215)));
      repeat (30) begin
        if ($urandom_range(9) < 7) queue_item(OP_TICK, 8'($urandom));
        else queue_item(OP_BYTE, stray_byte());
      end
    end

    while (n_queued < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) repeat ($urandom_range(1, 6)) queue_item(OP_TICK, 8'($urandom));
      else if (pick < 70) queue_frame(FR_GOOD, 1'b1);
      else if (pick < 80) queue_frame(FR_BAD_BLK, 1'b1);
      else if (pick < 90) queue_frame(FR_BAD_CPL, 1'b1);
      else queue_frame(FR_BAD_SUM, 1'b1);
    end

    // only one way to end the transfer per run, since reset comes once
    finale = ending_t'($urandom_range(2));
    case (finale)
      END_EOT: queue_item(OP_BYTE, CH_EOT);
      END_CAN: queue_item(OP_BYTE, CH_CAN);
      default: queue_item(OP_BYTE, stray_byte());
    endcase

    // everything after the end must be ignored
    repeat (20) begin
      pick = $urandom_range(4);
      if (pick == 0) queue_item(OP_TICK, 8'($urandom));
      else if (pick == 1) queue_item(OP_BYTE, CH_SOH);
      else if (pick == 2) queue_item(OP_BYTE, CH_EOT);
      else if (pick == 3) queue_item(OP_BYTE, CH_CAN);
      else queue_item(OP_BYTE, 8'($urandom));
    end

    while (results_seen < n_queued) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0 && predicted_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: xmodem_checksum_receiver_core.f
rtl/core/xcr_pkg.sv
rtl/core/xcr_front.sv
rtl/core/xcr_cmd_queue.sv
rtl/core/xcr_back.sv
rtl/core/xmodem_checksum_receiver_core.sv
sim/testbench.sv
